// ----- hdl/tsqs_pkg.sv -----
`default_nettype none

package tsqs_pkg;

  localparam int RAW_W    = 12;
  localparam int X_W      = 8;
  localparam int Y_W      = 9;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 4;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_SCREEN_WIDTH  = 240;
  localparam int DEF_SCREEN_HEIGHT = 320;

  localparam logic [RAW_W-1:0] PRESS_HIGH_LIMIT  = 12'd4000;
  localparam logic [RAW_W-1:0] PRESS_LOW_LIMIT   = 12'd10;
  localparam logic [RAW_W-1:0] PRESS_UPPER_BOUND = 12'd3500;
  localparam logic [RAW_W-1:0] PRESS_MAX_DIFF    = 12'd1000;
  localparam logic [RAW_W-1:0] RAW_HIGH_LIMIT    = 12'd4000;
  localparam logic [LIMIT_W-1:0] STUCK_SATURATE  = 4'd15;

  localparam logic [RAW_W-1:0]   RST_CAL_MIN       = 12'd200;
  localparam logic [RAW_W-1:0]   RST_CAL_MAX       = 12'd3900;
  localparam logic [RAW_W-1:0]   RST_PRESS_THRESH  = 12'd150;
  localparam logic [LIMIT_W-1:0] RST_STUCK_LIMIT   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT     = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE   = 2'd0,
    ST_FRESH  = 2'd1,
    ST_HELD   = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUAL,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0] pressure_one;
    logic [RAW_W-1:0] pressure_two;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [X_W-1:0]      x_coord;
    logic [Y_W-1:0]      y_coord;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [RAW_W-1:0]     value;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/tsqs_stream_if.sv -----
`default_nettype none

interface tsqs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/tsqs_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits, so the upper dividend bits start as the
// partial remainder and only QW steps are needed.
module tsqs_div #(
  parameter int QW = 9,
  parameter int DW = tsqs_pkg::RAW_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DW+QW-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic                  done,
  output logic [QW-1:0]         quotient
);
  import tsqs_pkg::*;

  localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [QW-1:0]    low;
  logic [DW:0]      trial;
  logic             fits;

  assign trial    = {rem, low[QW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DW+QW-1:QW];
      low <= dividend[QW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DW-1:0];
      end
      low <= {low[QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/touch_sample_qualifier_scaler.sv -----
// A sample without touch or with a bad raw reading goes from S_QUAL straight to S_OUT;
// a scaled sample passes S_MUL and S_DIV for each axis (S_DIV is skipped when a window
// is empty), then S_FIN and S_OUT. Both axes share one multiplier and a radix-2 divider
// with a Q-bit quotient, Q being the bit count of the larger screen dimension. The block
// takes one sample at a time: a new transfer waits for the result transfer.
// Reset (synchronous, active high) loads the register defaults and clears state.
`default_nettype none

module touch_sample_qualifier_scaler #(
  parameter int SCREEN_WIDTH  = tsqs_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tsqs_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  tsqs_stream_if.sink    sample,
  tsqs_stream_if.source  result,
  tsqs_stream_if.sink    cfg
);
  import tsqs_pkg::*;

  localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QW       = $clog2(SIZE_MAX + 1);
  localparam int NW       = RAW_W + QW;

  localparam logic [QW-1:0]  SIZE_X = QW'(SCREEN_WIDTH);
  localparam logic [QW-1:0]  SIZE_Y = QW'(SCREEN_HEIGHT);
  localparam logic [X_W-1:0] X_LAST = X_W'(SCREEN_WIDTH - 1);
  localparam logic [Y_W-1:0] Y_LAST = Y_W'(SCREEN_HEIGHT - 1);

  state_t state, state_next;

  // Configuration registers.
  logic [RAW_W-1:0]   cal_min_x, cal_max_x, cal_min_y, cal_max_y;
  logic [RAW_W-1:0]   touch_level;
  logic [LIMIT_W-1:0] stuck_limit;

  // Block state.
  logic [LIMIT_W-1:0] stuck_count;
  logic [X_W-1:0]     last_x;
  logic [Y_W-1:0]     last_y;

  // Working registers for the sample in flight.
  logic [RAW_W-1:0] z1, z2, rx, ry;
  logic             axis;
  logic [X_W-1:0]   x_new;
  logic [Y_W-1:0]   y_new;
  result_t          res;

  // Qualification.
  logic [RAW_W-1:0]   press_diff;
  logic               press_ok;
  logic               raw_bad;
  logic [LIMIT_W-1:0] stuck_inc;
  logic               reject;
  result_t            impl_res;
  logic               corner;

  // Per-axis scaling.
  logic [RAW_W-1:0] raw_sel, lo_sel, hi_sel, raw_c, diff, span;
  logic [QW-1:0]    size_sel;
  logic             span_ok;
  logic [NW-1:0]    product;
  logic             div_start;
  logic             div_done;
  logic [QW-1:0]    quo;
  logic [QW-1:0]    quo_c;
  logic [QW+Y_W:0]  quo_ext;

  assign press_diff = (z1 > z2) ? (z1 - z2) : (z2 - z1);
  assign press_ok   = !(z1 >= PRESS_HIGH_LIMIT || z2 >= PRESS_HIGH_LIMIT ||
                        z1 <= PRESS_LOW_LIMIT || z2 <= PRESS_LOW_LIMIT) &&
                      (z1 > touch_level) && (z1 < PRESS_UPPER_BOUND) &&
                      (z2 < PRESS_UPPER_BOUND) && (press_diff <= PRESS_MAX_DIFF);
  assign raw_bad    = (rx >= RAW_HIGH_LIMIT) || (ry >= RAW_HIGH_LIMIT) ||
                      (rx == '0) || (ry == '0);

  assign stuck_inc = (stuck_count == STUCK_SATURATE) ? stuck_count : stuck_count + 1'b1;
  assign reject    = (stuck_inc >= stuck_limit) || (last_x == '0 && last_y == '0);

  always_comb begin
    if (reject) begin
      impl_res.status  = ST_REJECT;
      impl_res.x_coord = '0;
      impl_res.y_coord = '0;
    end else begin
      impl_res.status  = ST_HELD;
      impl_res.x_coord = last_x;
      impl_res.y_coord = last_y;
    end
  end

  assign corner = (x_new == X_LAST) && (y_new == Y_LAST);

  assign raw_sel  = axis ? ry : rx;
  assign lo_sel   = axis ? cal_min_y : cal_min_x;
  assign hi_sel   = axis ? cal_max_y : cal_max_x;
  assign size_sel = axis ? SIZE_Y : SIZE_X;
  assign span_ok  = hi_sel > lo_sel;

  always_comb begin
    raw_c = raw_sel;
    if (raw_c < lo_sel) begin
      raw_c = lo_sel;
    end
    if (raw_c > hi_sel) begin
      raw_c = hi_sel;
    end
  end

  assign diff    = raw_c - lo_sel;
  assign span    = hi_sel - lo_sel;
  assign product = NW'(diff) * NW'(size_sel);

  // The point may land exactly on the screen size when raw sits at the top of
  // the window; that is pulled back onto the last pixel.
  assign quo_c   = (quo >= size_sel) ? size_sel - 1'b1 : quo;
  assign quo_ext = {{(Y_W + 1){1'b0}}, quo_c};

  tsqs_div #(
    .QW (QW),
    .DW (RAW_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (span),
    .done     (div_done),
    .quotient (quo)
  );

  assign sample.ready = (state == S_IDLE);
  assign result.valid = (state == S_OUT);
  assign result.data  = res;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (sample.valid) begin
          state_next = S_QUAL;
        end
      end
      S_QUAL: begin
        if (!press_ok || raw_bad) begin
          state_next = S_OUT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (span_ok) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (axis) begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = axis ? S_FIN : S_MUL;
        end
      end
      S_FIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_min_x       <= RST_CAL_MIN;
      cal_max_x       <= RST_CAL_MAX;
      cal_min_y       <= RST_CAL_MIN;
      cal_max_y       <= RST_CAL_MAX;
      touch_level     <= RST_PRESS_THRESH;
      stuck_limit     <= RST_STUCK_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_CAL_MIN_X:       cal_min_x       <= cfg.data.value;
        REG_CAL_MAX_X:       cal_max_x       <= cfg.data.value;
        REG_CAL_MIN_Y:       cal_min_y       <= cfg.data.value;
        REG_CAL_MAX_Y:       cal_max_y       <= cfg.data.value;
        REG_TOUCH_LEVEL:     touch_level     <= cfg.data.value;
        REG_STUCK_LIMIT:     stuck_limit     <= cfg.data.value[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stuck_count <= '0;
      last_x      <= '0;
      last_y      <= '0;
    end else begin
      case (state)
        S_QUAL: begin
          if (!press_ok) begin
            stuck_count <= '0;
          end else if (raw_bad) begin
            stuck_count <= stuck_inc;
          end
        end
        S_FIN: begin
          if (corner) begin
            stuck_count <= stuck_inc;
          end else begin
            stuck_count <= '0;
            last_x      <= x_new;
            last_y      <= y_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        z1 <= sample.data.pressure_one;
        z2 <= sample.data.pressure_two;
        rx <= sample.data.raw_x;
        ry <= sample.data.raw_y;
      end
      S_QUAL: begin
        axis <= 1'b0;
        if (!press_ok) begin
          res.status  <= ST_NONE;
          res.x_coord <= '0;
          res.y_coord <= '0;
        end else if (raw_bad) begin
          res <= impl_res;
        end
      end
      S_MUL: begin
        if (!span_ok) begin
          if (axis) begin
            y_new <= '0;
          end else begin
            x_new <= '0;
          end
          axis <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (axis) begin
            y_new <= quo_ext[Y_W-1:0];
          end else begin
            x_new <= quo_ext[X_W-1:0];
          end
          axis <= 1'b1;
        end
      end
      S_FIN: begin
        if (corner) begin
          res <= impl_res;
        end else begin
          res.status  <= ST_FRESH;
          res.x_coord <= x_new;
          res.y_coord <= y_new;
        end
      end
      default: begin
      end
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> !result.valid)
    else $error("input taken while a result is pending");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.data.status == ST_NONE || result.data.status == ST_FRESH)
    |-> stuck_count == '0)
    else $error("stuck count not cleared with a clean result");

  a_held_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.status == ST_HELD
    |-> stuck_count != '0 && result.data.x_coord == last_x &&
        result.data.y_coord == last_y && (last_x != '0 || last_y != '0))
    else $error("held result does not match the last good point");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tsqs_pkg::*;

  localparam int SCREEN_W = DEF_SCREEN_WIDTH;
  localparam int SCREEN_H = DEF_SCREEN_HEIGHT;
  localparam logic [X_W-1:0] X_LAST = X_W'(SCREEN_W - 1);
  localparam logic [Y_W-1:0] Y_LAST = Y_W'(SCREEN_H - 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_STUCK_LIMIT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int MAX_REPORTS = 200;

  logic clk = 1'b0;
  logic rst;

  tsqs_stream_if #(.T(sample_t)) sample_ch ();
  tsqs_stream_if #(.T(result_t)) result_ch ();
  tsqs_stream_if #(.T(cfg_t))    cfg_ch ();

  touch_sample_qualifier_scaler uut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  sample_t samples_pending[$];
  result_t touch_expected[$];
  result_t oldest_touch;

  logic sample_fire;
  logic cfg_fire;
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int results_seen;
  int quiet_cycles;

  // Predictor copy of the block's registers and state.
  logic [RAW_W-1:0]   win_lo_x, win_hi_x, win_lo_y, win_hi_y, press_min;
  logic [LIMIT_W-1:0] stuck_lim;
  logic [LIMIT_W-1:0] bad_run;
  logic [X_W-1:0]     last_x;
  logic [Y_W-1:0]     last_y;

  // Register values the stimulus is shaped for in the current phase.
  logic [RAW_W-1:0] plan_cfg [0:REG_STUCK_LIMIT];

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned to_screen(input int unsigned raw, input int unsigned lo,
                                            input int unsigned hi, input int unsigned span);
    int unsigned v;
    if (hi <= lo) begin
      return 0;
    end
    if (raw < lo) raw = lo;
    if (raw > hi) raw = hi;
    v = ((raw - lo) * span) / (hi - lo);
    if (v >= span) v = span - 1;
    return v;
  endfunction

  function automatic result_t predict_touch(input sample_t s);
    int unsigned z1, z2, diff, px, py;
    logic touched, bad;
    result_t r;
    z1 = s.pressure_one;
    z2 = s.pressure_two;
    diff = (z1 > z2) ? z1 - z2 : z2 - z1;
    r = '0;
    touched = z1 < PRESS_HIGH_LIMIT && z2 < PRESS_HIGH_LIMIT &&
              z1 > PRESS_LOW_LIMIT && z2 > PRESS_LOW_LIMIT &&
              z1 > press_min && z1 < PRESS_UPPER_BOUND && z2 < PRESS_UPPER_BOUND &&
              diff <= PRESS_MAX_DIFF;
    if (!touched) begin
      bad_run = '0;
      r.status = ST_NONE;
    end else begin
      bad = s.raw_x == 0 || s.raw_y == 0 ||
            s.raw_x >= RAW_HIGH_LIMIT || s.raw_y >= RAW_HIGH_LIMIT;
      px = to_screen(s.raw_x, win_lo_x, win_hi_x, SCREEN_W);
      py = to_screen(s.raw_y, win_lo_y, win_hi_y, SCREEN_H);
      // A reading that lands on the far corner is treated like a bad one.
      if (px[X_W-1:0] == X_LAST && py[Y_W-1:0] == Y_LAST) bad = 1'b1;
      if (bad) begin
        if (bad_run < STUCK_SATURATE) bad_run = bad_run + 1'b1;
        if (bad_run >= stuck_lim || (last_x == '0 && last_y == '0)) begin
          r.status = ST_REJECT;
        end else begin
          r.status  = ST_HELD;
          r.x_coord = last_x;
          r.y_coord = last_y;
        end
      end else begin
        bad_run   = '0;
        last_x    = px[X_W-1:0];
        last_y    = py[Y_W-1:0];
        r.status  = ST_FRESH;
        r.x_coord = last_x;
        r.y_coord = last_y;
      end
    end
    return r;
  endfunction

  function automatic sample_t sample_of(input int z1, input int z2, input int rx, input int ry);
    sample_t s;
    s.pressure_one = z1[RAW_W-1:0];
    s.pressure_two = z2[RAW_W-1:0];
    s.raw_x        = rx[RAW_W-1:0];
    s.raw_y        = ry[RAW_W-1:0];
    return s;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(input bit bad, input int lo, input int hi);
    int v;
    if (bad) begin
      case ($urandom_range(2))
        0: v = 0;
        1: v = RAW_HIGH_LIMIT;
        default: v = $urandom_range(4095, RAW_HIGH_LIMIT);
      endcase
    end else begin
      case ($urandom_range(9))
        0: v = 1;
        1: v = RAW_HIGH_LIMIT - 1;
        2: v = lo + $urandom_range(2) - 1;
        3: v = hi + $urandom_range(2) - 1;
        default: v = $urandom_range(RAW_HIGH_LIMIT - 1, 1);
      endcase
      if (v < 1) v = 1;
      if (v > RAW_HIGH_LIMIT - 1) v = RAW_HIGH_LIMIT - 1;
    end
    return v[RAW_W-1:0];
  endfunction

  // Builds a sample; its pressure pair mostly qualifies where the threshold allows.
  function automatic sample_t make_touch(input bit implausible);
    sample_t s;
    int lo, z1, z2, kind;
    lo = plan_cfg[REG_TOUCH_LEVEL] + 1;
    if (lo <= PRESS_LOW_LIMIT) lo = PRESS_LOW_LIMIT + 1;
    if (lo >= PRESS_UPPER_BOUND) z1 = $urandom_range(4095);
    else z1 = $urandom_range(PRESS_UPPER_BOUND - 1, lo);
    case ($urandom_range(9))
      0: z2 = z1 + PRESS_MAX_DIFF;
      1: z2 = z1 - PRESS_MAX_DIFF;
      2: z2 = z1 + PRESS_MAX_DIFF + 1;
      3: z2 = z1 - PRESS_MAX_DIFF - 1;
      default: z2 = z1 + $urandom_range(2 * PRESS_MAX_DIFF) - PRESS_MAX_DIFF;
    endcase
    if (z2 <= PRESS_LOW_LIMIT || z2 >= PRESS_UPPER_BOUND) z2 = z1;
    kind = implausible ? $urandom_range(3) : 4;
    s.pressure_one = z1[RAW_W-1:0];
    s.pressure_two = z2[RAW_W-1:0];
    s.raw_x = pick_raw(kind == 0 || kind == 2, plan_cfg[REG_CAL_MIN_X], plan_cfg[REG_CAL_MAX_X]);
    s.raw_y = pick_raw(kind == 1 || kind == 2, plan_cfg[REG_CAL_MIN_Y], plan_cfg[REG_CAL_MAX_Y]);
    if (kind == 3) begin
      s.raw_x = RAW_W'((plan_cfg[REG_CAL_MAX_X] >= RAW_HIGH_LIMIT) ? RAW_HIGH_LIMIT - 1 :
                       $urandom_range(RAW_HIGH_LIMIT - 1, plan_cfg[REG_CAL_MAX_X]));
      s.raw_y = RAW_W'((plan_cfg[REG_CAL_MAX_Y] >= RAW_HIGH_LIMIT) ? RAW_HIGH_LIMIT - 1 :
                       $urandom_range(RAW_HIGH_LIMIT - 1, plan_cfg[REG_CAL_MAX_Y]));
    end
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
    end
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= {idx, val};
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (samples_pending.size() != 0 || touch_expected.size() != 0);
  endtask

  // Sample driver: an offered item stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (sample_fire) void'(samples_pending.pop_front());
      if (!sample_ch.valid || sample_fire) begin
        if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_ch.valid <= 1'b1;
          sample_ch.data  <= samples_pending[0];
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end else begin
      sample_ch.valid <= 1'b0;
      sample_ch.data  <= '0;
    end
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on each sample transfer and checks each result transfer.
  always @(posedge clk) begin
    if (rst) begin
      sample_fire  <= 1'b0;
      cfg_fire     <= 1'b0;
      quiet_cycles <= 0;
      mismatches   = 0;
      results_seen = 0;
      win_lo_x     = RST_CAL_MIN;
      win_hi_x     = RST_CAL_MAX;
      win_lo_y     = RST_CAL_MIN;
      win_hi_y     = RST_CAL_MAX;
      press_min    = RST_PRESS_THRESH;
      stuck_lim    = RST_STUCK_LIMIT;
      bad_run      = '0;
      last_x       = '0;
      last_y       = '0;
    end else begin
      sample_fire <= sample_ch.valid && sample_ch.ready;
      cfg_fire    <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_CAL_MIN_X:       win_lo_x  = cfg_ch.data.value;
          REG_CAL_MAX_X:       win_hi_x  = cfg_ch.data.value;
          REG_CAL_MIN_Y:       win_lo_y  = cfg_ch.data.value;
          REG_CAL_MAX_Y:       win_hi_y  = cfg_ch.data.value;
          REG_TOUCH_LEVEL:     press_min = cfg_ch.data.value;
          REG_STUCK_LIMIT:     stuck_lim = cfg_ch.data.value[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        touch_expected.push_back(predict_touch(sample_ch.data));
      end
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (touch_expected.size() == 0) begin
          report_mismatch($sformatf("status %0d arrived with no result pending",
                                    result_ch.data.status));
        end else begin
          oldest_touch = touch_expected.pop_front();
          if (result_ch.data.status !== oldest_touch.status)
            report_mismatch($sformatf("status got %0d, want %0d",
                                      result_ch.data.status, oldest_touch.status));
          if (result_ch.data.x_coord !== oldest_touch.x_coord)
            report_mismatch($sformatf("x_coord got %0d, want %0d",
                                      result_ch.data.x_coord, oldest_touch.x_coord));
          if (result_ch.data.y_coord !== oldest_touch.y_coord)
            report_mismatch($sformatf("y_coord got %0d, want %0d",
                                      result_ch.data.y_coord, oldest_touch.y_coord));
        end
      end
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("** touch_sample_qualifier_scaler: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase, n, burst, pick, count;
    logic [63:0] noise;
    logic [RAW_W-1:0] wval;

    rst             = 1'b1;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    plan_cfg[REG_CAL_MIN_X]       = RST_CAL_MIN;
    plan_cfg[REG_CAL_MAX_X]       = RST_CAL_MAX;
    plan_cfg[REG_CAL_MIN_Y]       = RST_CAL_MIN;
    plan_cfg[REG_CAL_MAX_Y]       = RST_CAL_MAX;
    plan_cfg[REG_TOUCH_LEVEL]     = RST_PRESS_THRESH;
    plan_cfg[REG_STUCK_LIMIT]     = RST_STUCK_LIMIT;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples at the reset register values.
    @(posedge clk);
    samples_pending.push_back(sample_of(2000, 2000, 0, 2000));    // bad X, nothing held yet
    samples_pending.push_back(sample_of(2000, 2000, 2000, 4000));
    samples_pending.push_back(sample_of(4000, 2000, 2000, 2000)); // pressure too high
    samples_pending.push_back(sample_of(2000, 10, 2000, 2000));   // pressure too low
    samples_pending.push_back(sample_of(150, 150, 2000, 2000));   // at the threshold
    samples_pending.push_back(sample_of(3500, 3000, 2000, 2000));
    samples_pending.push_back(sample_of(2000, 3500, 2000, 2000));
    samples_pending.push_back(sample_of(2000, 999, 2000, 2000));  // pair too far apart
    samples_pending.push_back(sample_of(2000, 1000, 2000, 2000));
    samples_pending.push_back(sample_of(151, 11, 200, 3900));
    samples_pending.push_back(sample_of(3499, 3499, 1, 1));
    samples_pending.push_back(sample_of(3000, 2500, 3999, 1));
    samples_pending.push_back(sample_of(3000, 2500, 3999, 3999)); // far corner
    samples_pending.push_back(sample_of(3000, 2500, 4095, 1));
    repeat (11) samples_pending.push_back(sample_of(2500, 2500, 1, 4095));
    samples_pending.push_back(sample_of(0, 0, 0, 0));
    samples_pending.push_back(sample_of(4095, 4095, 4095, 4095));
    samples_pending.push_back(sample_of(2500, 2500, 0, 1));
    wait_drained();

    for (phase = 1; phase <= 8; phase++) begin
      case (phase)
        1: begin
          plan_cfg = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd15};
        end
        2: begin
          // Inverted X window and empty Y window both give coordinate zero.
          plan_cfg = '{12'd4095, 12'd0, 12'd1000, 12'd1000, 12'd11, 12'd1};
        end
        3: begin
          plan_cfg = '{12'd200, 12'd3900, 12'd200, 12'd3900, 12'd150, 12'd0};
        end
        4: begin
          plan_cfg = '{12'd300, 12'd301, 12'd3998, 12'd3999, 12'd4095, 12'd5};
        end
        default: begin
          plan_cfg[REG_CAL_MIN_X] = RAW_W'($urandom_range(1500));
          plan_cfg[REG_CAL_MAX_X] = RAW_W'(($urandom_range(9) == 0) ? $urandom_range(4095) :
                                    plan_cfg[REG_CAL_MIN_X] + $urandom_range(2595, 2));
          plan_cfg[REG_CAL_MIN_Y] = RAW_W'($urandom_range(1500));
          plan_cfg[REG_CAL_MAX_Y] = RAW_W'(($urandom_range(9) == 0) ? $urandom_range(4095) :
                                    plan_cfg[REG_CAL_MIN_Y] + $urandom_range(2595, 2));
          plan_cfg[REG_TOUCH_LEVEL]     = RAW_W'($urandom_range(3000));
          plan_cfg[REG_STUCK_LIMIT]     = RAW_W'($urandom_range(15));
        end
      endcase

      for (int i = 0; i <= REG_STUCK_LIMIT; i++) begin
        wval = plan_cfg[i[CFG_IDX_W-1:0]];
        if (i == REG_STUCK_LIMIT) wval[RAW_W-1:LIMIT_W] = (RAW_W - LIMIT_W)'($urandom);
        write_reg(i[CFG_IDX_W-1:0], wval);
      end
      if (phase == 2) begin
        write_reg(REG_SPARE_LO, 12'($urandom));
        write_reg(REG_SPARE_HI, 12'($urandom));
      end

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase

      // With the threshold at full scale nothing qualifies, so that phase stays short.
      count = (phase == 4) ? 30 : ITEMS_PER_PHASE;
      n = 0;
      @(posedge clk);
      while (n < count) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          noise = {$urandom, $urandom};
          samples_pending.push_back(noise[$bits(sample_t)-1:0]);
          n++;
        end else if (pick < 14) begin
          // Long runs of bad readings drive the stuck counter into saturation.
          burst = $urandom_range(18, 3);
          repeat (burst) samples_pending.push_back(make_touch(1'b1));
          n += burst;
        end else if (pick < 24) begin
          samples_pending.push_back(make_touch(1'b1));
          n++;
        end else begin
          samples_pending.push_back(make_touch(1'b0));
          n++;
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && touch_expected.size() == 0) begin
      $display("** touch_sample_qualifier_scaler: PASSED **");
    end else begin
      $display("** touch_sample_qualifier_scaler: FAILED **");
    end
    $finish;
  end

endmodule
